// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the scaler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// File: sv/mfbs_pkg.sv
// ----------------------------------------------------------------------------
// mfbs_pkg
// Constants, codes and controller/datapath interface types of the scaler.
// ----------------------------------------------------------------------------
`default_nettype none
package mfbs_pkg;

   localparam int MAX_LW      = 128;
   localparam int MAX_LH      = 64;
   localparam int MAX_PW      = 256;
   localparam int MAX_PH      = 128;
   localparam int STORE_DEPTH = ((MAX_LW + 7) / 8) * MAX_LH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int DIV_W       = 16;

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_LW = 2'd0,
      REG_LH = 2'd1,
      REG_PW = 2'd2,
      REG_PH = 2'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_BIT_CHK,
      ST_DIVX_WAIT,
      ST_MEM_READ,
      ST_BIT_SET,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic clr_write;
      logic wr_read;
      logic wr_write;
      logic divy_start;
      logic sy_load;
      logic divx_start;
      logic sx_load;
      logic mem_read;
      logic bit_set;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         clr_last;
      logic         wr_ok;
      logic         rd_in_range;
      logic         div_done;
      logic         bit_past;
      logic         bit_last;
      logic         out_free;
   } status_type;

endpackage
`default_nettype wire

// File: sv/mfbs_ram.sv
// ----------------------------------------------------------------------------
// mfbs_ram
// Generic single-clock RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module mfbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: sv/mfbs_div.sv
// ----------------------------------------------------------------------------
// mfbs_div
// Restoring divider, one quotient bit per cycle, sixteen steps per divide.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mfbs_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [mfbs_pkg::DIV_W-1:0] dividend,
   input  wire logic [8:0]                divisor,
   output logic                           done,
   output logic [mfbs_pkg::DIV_W-1:0]     quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [3:0]                    cnt_ff, cnt_in;
   logic [7:0]                    rem_ff, rem_in;
   logic [mfbs_pkg::DIV_W-1:0]    q_ff, q_in;
   logic [8:0]                    div_ff, div_in;
   logic [8:0]                    trial;

   assign trial = {rem_ff, q_ff[mfbs_pkg::DIV_W-1]};

   // one subtract-and-shift step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= div_ff) begin
            rem_in = 8'(trial - div_ff);
            q_in   = {q_ff[mfbs_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[7:0];
            q_in   = {q_ff[mfbs_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

   `ASSERT_PROP(a_done_after_busy, clock, reset, done_ff |-> $past(busy_ff))

endmodule
`default_nettype wire

// File: sv/mfbs_ctrl.sv
// ----------------------------------------------------------------------------
// mfbs_ctrl
// Sequencer for pixel writes, store clears and scaled byte reads.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mfbs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire mfbs_pkg::status_type sts,
   output mfbs_pkg::cmd_type         cmd
);

   mfbs_pkg::state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mfbs_pkg::ST_CLEAR: begin
            if (sts.clr_last) state_in = mfbs_pkg::ST_IDLE;
         end
         mfbs_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = mfbs_pkg::ST_DISPATCH;
         end
         mfbs_pkg::ST_DISPATCH: begin
            case (sts.kind)
               mfbs_pkg::REQ_WRITE:
                  state_in = sts.wr_ok ? mfbs_pkg::ST_WR_READ : mfbs_pkg::ST_IDLE;
               mfbs_pkg::REQ_CLEAR: state_in = mfbs_pkg::ST_CLEAR;
               mfbs_pkg::REQ_READ:
                  state_in = sts.rd_in_range ? mfbs_pkg::ST_DIVY_GO : mfbs_pkg::ST_RESULT;
               default: state_in = mfbs_pkg::ST_IDLE;
            endcase
         end
         mfbs_pkg::ST_WR_READ:   state_in = mfbs_pkg::ST_WR_WRITE;
         mfbs_pkg::ST_WR_WRITE:  state_in = mfbs_pkg::ST_IDLE;
         mfbs_pkg::ST_DIVY_GO:   state_in = mfbs_pkg::ST_DIVY_WAIT;
         mfbs_pkg::ST_DIVY_WAIT: begin
            if (sts.div_done) state_in = mfbs_pkg::ST_BIT_CHK;
         end
         mfbs_pkg::ST_BIT_CHK: begin
            state_in = sts.bit_past ? mfbs_pkg::ST_RESULT : mfbs_pkg::ST_DIVX_WAIT;
         end
         mfbs_pkg::ST_DIVX_WAIT: begin
            if (sts.div_done) state_in = mfbs_pkg::ST_MEM_READ;
         end
         mfbs_pkg::ST_MEM_READ:  state_in = mfbs_pkg::ST_BIT_SET;
         mfbs_pkg::ST_BIT_SET: begin
            state_in = sts.bit_last ? mfbs_pkg::ST_RESULT : mfbs_pkg::ST_BIT_CHK;
         end
         mfbs_pkg::ST_RESULT: begin
            if (sts.out_free) state_in = mfbs_pkg::ST_IDLE;
         end
         default: state_in = mfbs_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         mfbs_pkg::ST_CLEAR: cmd.clr_write = 1'b1;
         mfbs_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         mfbs_pkg::ST_WR_READ:   cmd.wr_read    = 1'b1;
         mfbs_pkg::ST_WR_WRITE:  cmd.wr_write   = 1'b1;
         mfbs_pkg::ST_DIVY_GO:   cmd.divy_start = 1'b1;
         mfbs_pkg::ST_DIVY_WAIT: cmd.sy_load    = sts.div_done;
         mfbs_pkg::ST_BIT_CHK:   cmd.divx_start = !sts.bit_past;
         mfbs_pkg::ST_DIVX_WAIT: cmd.sx_load    = sts.div_done;
         mfbs_pkg::ST_MEM_READ:  cmd.mem_read   = 1'b1;
         mfbs_pkg::ST_BIT_SET:   cmd.bit_set    = 1'b1;
         mfbs_pkg::ST_RESULT:    cmd.out_load   = sts.out_free;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfbs_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_PROP(a_clear_walk_holds, clock, reset,
      (state_ff == mfbs_pkg::ST_CLEAR && !sts.clr_last) |=> state_ff == mfbs_pkg::ST_CLEAR)
   `ASSERT_PROP(a_divx_then_wait, clock, reset,
      cmd.divx_start |=> state_ff == mfbs_pkg::ST_DIVX_WAIT)
   `ASSERT_NEVER(a_ram_port_clash, clock, reset,
      (cmd.clr_write || cmd.wr_write) && (cmd.wr_read || cmd.mem_read))

endmodule
`default_nettype wire

// File: sv/mfbs_dp.sv
// ----------------------------------------------------------------------------
// mfbs_dp
// Datapath: size registers, request capture, pixel store, divider and result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module mfbs_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mfbs_pkg::cmd_type     cmd,
   output mfbs_pkg::status_type       sts,
   input  wire logic [1:0]            req_tuser,
   input  wire logic [39:0]           req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic                       rsp_tuser,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [3:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata
);

   // size registers
   logic [7:0] lw_reg_ff;
   logic [6:0] lh_reg_ff;
   logic [8:0] pw_reg_ff;
   logic [7:0] ph_reg_ff;
   mfbs_pkg::csr_reg_type csr_idx;
   logic csr_wr;

   assign csr_idx = mfbs_pkg::csr_reg_type'(csr_paddr[3:2]);
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_reg_ff <= 8'd64;
         lh_reg_ff <= 7'd32;
         pw_reg_ff <= 9'd128;
         ph_reg_ff <= 8'd64;
      end else if (csr_wr) begin
         case (csr_idx)
            mfbs_pkg::REG_LW: lw_reg_ff <= csr_pwdata[7:0];
            mfbs_pkg::REG_LH: lh_reg_ff <= csr_pwdata[6:0];
            mfbs_pkg::REG_PW: pw_reg_ff <= csr_pwdata[8:0];
            mfbs_pkg::REG_PH: ph_reg_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         mfbs_pkg::REG_LW: csr_prdata = 32'(lw_reg_ff);
         mfbs_pkg::REG_LH: csr_prdata = 32'(lh_reg_ff);
         mfbs_pkg::REG_PW: csr_prdata = 32'(pw_reg_ff);
         mfbs_pkg::REG_PH: csr_prdata = 32'(ph_reg_ff);
         default: csr_prdata = '0;
      endcase
   end

   // clamp sizes to [1, max]
   logic [7:0] lw;
   logic [6:0] lh;
   logic [8:0] pw;
   logic [7:0] ph;
   logic [4:0] stride;

   always_comb begin
      lw = (lw_reg_ff == '0) ? 8'd1 :
           (lw_reg_ff > 8'(mfbs_pkg::MAX_LW)) ? 8'(mfbs_pkg::MAX_LW) : lw_reg_ff;
      lh = (lh_reg_ff == '0) ? 7'd1 :
           (lh_reg_ff > 7'(mfbs_pkg::MAX_LH)) ? 7'(mfbs_pkg::MAX_LH) : lh_reg_ff;
      pw = (pw_reg_ff == '0) ? 9'd1 :
           (pw_reg_ff > 9'(mfbs_pkg::MAX_PW)) ? 9'(mfbs_pkg::MAX_PW) : pw_reg_ff;
      ph = (ph_reg_ff == '0) ? 8'd1 :
           (ph_reg_ff > 8'(mfbs_pkg::MAX_PH)) ? 8'(mfbs_pkg::MAX_PH) : ph_reg_ff;
      stride = 5'((9'(lw) + 9'd7) >> 3);
   end

   // capture request on transfer
   mfbs_pkg::req_kind_type kind_ff;
   logic [9:0] x_ff, y_ff;
   logic       on_ff;
   logic [6:0] row_ff;
   logic [4:0] bcol_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= mfbs_pkg::req_kind_type'(req_tuser);
         x_ff    <= req_tdata[9:0];
         y_ff    <= req_tdata[19:10];
         on_ff   <= req_tdata[20];
         row_ff  <= req_tdata[27:21];
         bcol_ff <= req_tdata[32:28];
      end
   end

   // pixel write address and bounds
   logic                            wr_ok;
   logic [mfbs_pkg::ADDR_W-1:0]     pix_addr;
   logic [10:0]                     pix_row_base;

   assign wr_ok = !x_ff[9] && !y_ff[9] && (x_ff[8:0] < 9'(lw)) && (y_ff[8:0] < 9'(lh));
   assign pix_row_base = 11'(y_ff[5:0]) * 11'(stride);
   assign pix_addr = pix_row_base[9:0] + 10'(x_ff[6:3]);

   // read walk state
   logic [2:0] bit_ff;
   logic [7:0] acc_ff;
   logic [5:0] sy_ff;
   logic [6:0] sx_ff;
   logic [7:0] px;
   logic       rd_in_range;
   logic [10:0] rd_row_base;
   logic [mfbs_pkg::ADDR_W-1:0] rd_addr;

   assign px          = {bcol_ff, bit_ff};
   assign rd_in_range = (8'(row_ff) < ph) && (9'({bcol_ff, 3'b000}) < pw);
   assign rd_row_base = 11'(sy_ff) * 11'(stride);
   assign rd_addr     = rd_row_base[9:0] + 10'(sx_ff[6:3]);

   // shared divider for source row and source column
   logic [mfbs_pkg::DIV_W-1:0] div_dividend, div_quot;
   logic [8:0]                 div_divisor;
   logic                       div_done;

   assign div_dividend = cmd.divx_start ?
      mfbs_pkg::DIV_W'(16'(px) * 16'(lw)) : mfbs_pkg::DIV_W'(16'(row_ff) * 16'(lh));
   assign div_divisor  = cmd.divx_start ? pw : 9'(ph);

   mfbs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.divy_start || cmd.divx_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // pixel store
   logic [mfbs_pkg::ADDR_W-1:0] clr_ff;
   logic [7:0] ram_rdata, ram_wdata, pix_mask;
   logic       ram_wr_en;

   assign pix_mask  = 8'd1 << x_ff[2:0];
   assign ram_wr_en = cmd.clr_write || cmd.wr_write;
   assign ram_wdata = cmd.clr_write ? 8'd0 :
                      (on_ff ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask));

   mfbs_ram #(
      .WIDTH (8),
      .DEPTH (mfbs_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cmd.clr_write ? clr_ff : pix_addr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.wr_read || cmd.mem_read),
      .rd_addr (cmd.mem_read ? rd_addr : pix_addr),
      .rd_data (ram_rdata)
   );

   // clear walk index
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_write) begin
         clr_ff <= clr_ff + mfbs_pkg::ADDR_W'(1);
      end
   end

   // source coordinates and assembled byte
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         bit_ff <= '0;
         acc_ff <= '0;
      end else if (cmd.bit_set) begin
         acc_ff[bit_ff] <= ram_rdata[sx_ff[2:0]];
         bit_ff         <= bit_ff + 3'd1;
      end
      if (cmd.sy_load) sy_ff <= div_quot[5:0];
      if (cmd.sx_load) sx_ff <= div_quot[6:0];
   end

   // output register, freed by a transfer
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_user_ff;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff <= acc_ff;
         rsp_user_ff <= rd_in_range;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // status to controller
   always_comb begin
      sts.kind        = kind_ff;
      sts.clr_last    = clr_ff == mfbs_pkg::ADDR_W'(mfbs_pkg::STORE_DEPTH - 1);
      sts.wr_ok       = wr_ok;
      sts.rd_in_range = rd_in_range;
      sts.div_done    = div_done;
      sts.bit_past    = 9'(px) >= pw;
      sts.bit_last    = bit_ff == 3'd7;
      sts.out_free    = out_free;
   end

   `ASSERT_PROP(a_load_only_when_free, clock, reset, cmd.out_load |-> out_free)

endmodule
`default_nettype wire

// File: sv/mono_framebuffer_nearest_scaler_core.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_nearest_scaler_core
// 1 bpp framebuffer with nearest-neighbor scaled byte readout.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Content
// req      in   tvalid/tready      tuser: kind; tdata: x, y, on, row, byte column
// rsp      out  tvalid/tready      tdata: eight pixels; tuser: in range
// csr      in   APB, pready high   four size registers at 0x0, 0x4, 0x8, 0xC
//
// Pixel write: read-modify-write of one store byte; an ignored write returns to idle.
// Clear: the whole store is swept to zero, one byte a cycle. Read: one row divide,
// then per pixel a column divide on the shared 16-step divider and a store read.
// After reset the store is swept to zero; req_tready stays low.
// A result waiting in the output register holds up only the next read's end.
// ----------------------------------------------------------------------------
`default_nettype none
module mono_framebuffer_nearest_scaler_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // pixel_x, pixel_y, pixel_on, out_row,
                                         // out_byte_col, zero pad
   input  wire logic [1:0]  req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_data
   output logic             rsp_tuser,   // in_range
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   mfbs_pkg::cmd_type    cmd;
   mfbs_pkg::status_type sts;

   assign csr_pready = 1'b1;

   mfbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mfbs_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule
`default_nettype wire

// File: verif/mono_framebuffer_nearest_scaler_core_tb.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_nearest_scaler_core_tb
// Drives pixel writes, clears and scaled byte reads through the request stream
// under several size settings, and checks every readout byte against a local
// shadow framebuffer with nearest-neighbor scaling.
// ----------------------------------------------------------------------------
`default_nettype none
module mono_framebuffer_nearest_scaler_core_tb;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      mfbs_pkg::req_kind_type kind;
      logic signed [9:0] px;
      logic signed [9:0] py;
      logic            on;
      logic [6:0]      row;
      logic [4:0]      bcol;
   } fb_req_type;

   typedef struct packed {
      logic [7:0] pixels;
      logic       in_range;
   } fb_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = mfbs_pkg::REQ_NONE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mono_framebuffer_nearest_scaler_core DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow framebuffer and size registers
   logic [7:0] shadow_fb [mfbs_pkg::STORE_DEPTH];
   logic [7:0] sz_lw = 8'd64;
   logic [6:0] sz_lh = 7'd32;
   logic [8:0] sz_pw = 9'd128;
   logic [7:0] sz_ph = 8'd64;

   fb_req_type  pending_reqs[$];
   fb_byte_type expected_bytes[$];
   logic     hold_sender = 1'b0;
   bit       req_sent = 1'b0;
   int       mismatches = 0;
   int       idle_cycles = 0;
   int       tx_gap = 0;
   int       rx_gap = 0;

   function automatic int eff_size(int v, int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
   endfunction

   // update the shadow store; return the expected readout byte for reads
   function automatic bit apply_request(fb_req_type r, output fb_byte_type res);
      int lw, lh, pw, ph, stride, sy, sx, pxl, idx;
      lw = eff_size(sz_lw, mfbs_pkg::MAX_LW);
      lh = eff_size(sz_lh, mfbs_pkg::MAX_LH);
      pw = eff_size(sz_pw, mfbs_pkg::MAX_PW);
      ph = eff_size(sz_ph, mfbs_pkg::MAX_PH);
      stride = (lw + 7) / 8;
      res = '0;
      case (r.kind)
         mfbs_pkg::REQ_WRITE: begin
            if (r.px >= 0 && r.py >= 0 && int'(r.px) < lw && int'(r.py) < lh) begin
               idx = int'(r.py) * stride + int'(r.px) / 8;
               if (idx < mfbs_pkg::STORE_DEPTH) shadow_fb[idx][r.px[2:0]] = r.on;
            end
            return 1'b0;
         end
         mfbs_pkg::REQ_CLEAR: begin
            foreach (shadow_fb[i]) shadow_fb[i] = '0;
            return 1'b0;
         end
         mfbs_pkg::REQ_READ: begin
            if (int'(r.row) < ph && int'(r.bcol) * 8 < pw) begin
               res.in_range = 1'b1;
               sy = int'(r.row) * lh / ph;
               for (int b = 0; b < 8; b++) begin
                  pxl = int'(r.bcol) * 8 + b;
                  if (pxl < pw) begin
                     sx = pxl * lw / pw;
                     idx = sy * stride + sx / 8;
                     if (idx < mfbs_pkg::STORE_DEPTH)
                        res.pixels[b] = shadow_fb[idx][sx % 8];
                  end
               end
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: present the next pending item and hold it until its transfer
   always @(negedge clock) begin
      if (!reset) begin
         if (tx_gap > 0) begin
            tx_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0 &&
                      (!hold_sender || (req_tvalid && !req_sent))) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_reqs[0].kind;
            req_tdata  <= {5'd0, pending_reqs[0].bcol, pending_reqs[0].row,
                           pending_reqs[0].on, pending_reqs[0].py, pending_reqs[0].px};
         end else begin
            req_tvalid <= 1'b0;
         end
         req_sent = 1'b0;
         // random stalls on the result side
         if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            rx_gap = pick_gap();
         end
      end
   end

   // monitor: predict on each request transfer, check each result transfer
   always @(posedge clock) begin
      fb_byte_type want;
      fb_byte_type res;
      fb_req_type  r;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready) begin
            r = pending_reqs.pop_front();
            if (apply_request(r, res)) expected_bytes.push_back(res);
            tx_gap = pick_gap();
            req_sent = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result: data %02h in_range %0b", rsp_tdata, rsp_tuser);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_tdata !== want.pixels || rsp_tuser !== want.in_range) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("read byte: expected %02h/%0b, got %02h/%0b",
                              want.pixels, want.in_range, rsp_tdata, rsp_tuser);
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mono_framebuffer_nearest_scaler_core: mismatch");
            $finish;
         end
      end
   end

   task automatic csr_write(mfbs_pkg::csr_reg_type idx, int value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (idx)
         mfbs_pkg::REG_LW: sz_lw = value[7:0];
         mfbs_pkg::REG_LH: sz_lh = value[6:0];
         mfbs_pkg::REG_PW: sz_pw = value[8:0];
         default: sz_ph = value[7:0];
      endcase
   endtask

   // wait until every item went out and every result came back
   task automatic drain();
      wait (pending_reqs.size() == 0 && expected_bytes.size() == 0);
      repeat (1100) @(posedge clock);
   endtask

   function automatic fb_req_type mk_write(int x, int y, bit on);
      fb_req_type r;
      r = '0; r.kind = mfbs_pkg::REQ_WRITE; r.px = 10'(x); r.py = 10'(y); r.on = on;
      return r;
   endfunction

   function automatic fb_req_type mk_read(int row, int bcol);
      fb_req_type r;
      r = '0; r.kind = mfbs_pkg::REQ_READ; r.row = 7'(row); r.bcol = 5'(bcol);
      return r;
   endfunction

   // random request: mostly in-range writes and reads, some noise
   function automatic fb_req_type rand_request();
      fb_req_type r;
      int sel;
      r = '0;
      r.px = 10'($urandom); r.py = 10'($urandom); r.on = 1'($urandom);
      r.row = 7'($urandom); r.bcol = 5'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         r.kind = mfbs_pkg::REQ_WRITE;
         if (sel < 38) begin
            r.px = 10'($urandom_range(0, eff_size(sz_lw, mfbs_pkg::MAX_LW) - 1));
            r.py = 10'($urandom_range(0, eff_size(sz_lh, mfbs_pkg::MAX_LH) - 1));
         end
      end else if (sel < 47) begin
         r.kind = mfbs_pkg::REQ_CLEAR;
      end else if (sel < 49) begin
         r.kind = mfbs_pkg::REQ_NONE;
      end else begin
         r.kind = mfbs_pkg::REQ_READ;
         if (sel < 92) begin
            r.row  = 7'($urandom_range(0, eff_size(sz_ph, mfbs_pkg::MAX_PH) - 1));
            r.bcol = 5'($urandom_range(0, (eff_size(sz_pw, mfbs_pkg::MAX_PW) - 1) / 8));
         end
      end
      return r;
   endfunction

   initial begin
      int sizes [5][4];
      fb_req_type r;
      foreach (shadow_fb[i]) shadow_fb[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: corners, sign extremes, all kinds, in-range and outside reads
      pending_reqs.push_back(mk_write(0, 0, 1'b1));
      pending_reqs.push_back(mk_write(63, 31, 1'b1));
      pending_reqs.push_back(mk_write(-512, 5, 1'b1));
      pending_reqs.push_back(mk_write(5, -1, 1'b1));
      pending_reqs.push_back(mk_write(511, 511, 1'b1));
      pending_reqs.push_back(mk_write(64, 0, 1'b1));
      pending_reqs.push_back(mk_write(7, 3, 1'b1));
      pending_reqs.push_back(mk_write(7, 3, 1'b0));
      pending_reqs.push_back(mk_read(0, 0));
      pending_reqs.push_back(mk_read(63, 15));
      pending_reqs.push_back(mk_read(127, 31));
      pending_reqs.push_back(mk_read(64, 0));
      pending_reqs.push_back(mk_read(0, 16));
      r = '0; r.kind = mfbs_pkg::REQ_NONE; r.px = -1; r.py = -1; r.on = 1;
      r.row = '1; r.bcol = '1;
      pending_reqs.push_back(r);
      r = '0; r.kind = mfbs_pkg::REQ_CLEAR;
      pending_reqs.push_back(r);
      pending_reqs.push_back(mk_read(63, 15));
      drain();

      // size settings: extremes, out-of-range values, odd ratios
      sizes = '{'{0, 0, 0, 0}, '{255, 127, 511, 255}, '{128, 64, 256, 128},
                '{13, 7, 21, 5}, '{64, 32, 128, 64}};
      for (int s = 0; s < 5; s++) begin
         csr_write(mfbs_pkg::REG_LW, sizes[s][0]);
         csr_write(mfbs_pkg::REG_LH, sizes[s][1]);
         csr_write(mfbs_pkg::REG_PW, sizes[s][2]);
         csr_write(mfbs_pkg::REG_PH, sizes[s][3]);
         for (int n = 0; n < 330; n++) pending_reqs.push_back(rand_request());
         if (s == 2) begin
            // pause the sender until all results are back
            wait (pending_reqs.size() < 200);
            hold_sender = 1'b1;
            wait (expected_bytes.size() == 0);
            repeat (20) @(posedge clock);
            hold_sender = 1'b0;
         end
         drain();
      end

      if (mismatches == 0 && expected_bytes.size() == 0)
         $display("mono_framebuffer_nearest_scaler_core: match");
      else
         $display("mono_framebuffer_nearest_scaler_core: mismatch");
      $finish;
   end
endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/mfbs_pkg.sv
sv/mfbs_ram.sv
sv/mfbs_div.sv
sv/mfbs_ctrl.sv
sv/mfbs_dp.sv
sv/mono_framebuffer_nearest_scaler_core.sv
verif/mono_framebuffer_nearest_scaler_core_tb.sv
